[design/number_range_list_expander_top_macros.svh]
// Assertion macros shared by the range list expander files.
// Each check is sampled on the rising edge of i_clk and is off during reset.
`ifndef NUMBER_RANGE_LIST_EXPANDER_TOP_MACROS_SVH
`define NUMBER_RANGE_LIST_EXPANDER_TOP_MACROS_SVH

`ifndef SYNTH
`define NRLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define NRLE_ASSERT_IMPLY(label, pre, post, msg) \
    `NRLE_ASSERT(label, (pre) |-> (post), msg)
`else
`define NRLE_ASSERT(label, prop, msg)
`define NRLE_ASSERT_IMPLY(label, pre, post, msg)
`endif

`endif

[design/nrle_pkg.sv]
package nrle_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        ACT_CHAR = 2'd0,
        ACT_END  = 2'd1,
        ACT_PULL = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_DESCEND  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_NUM1   = 3'd0,
        PH_SIGN1  = 3'd1,
        PH_DIG1   = 3'd2,
        PH_AFTER1 = 3'd3,
        PH_NUM2   = 3'd4,
        PH_SIGN2  = 3'd5,
        PH_DIG2   = 3'd6,
        PH_AFTER2 = 3'd7
    } t_phase;

    // One classified input transaction as it sits in the queue.
    typedef struct packed {
        t_action    kind;
        logic       is_digit;
        logic       is_space;
        logic       is_comma;
        logic       is_minus;
        logic       is_plus;
        logic [3:0] digit;
    } t_item;

    // Flag half of one result.
    typedef struct packed {
        logic    value_valid;
        logic    more_pending;
        logic    list_done;
        t_status status;
        logic    rejected;
    } t_flags;

endpackage

[design/number_range_list_expander_top.sv]
// Channel   Direction  tdata (low bit up)             tuser (low bit up)              tlast
// s_axis    in         char_code[7:0]                 action[1:0]                     -
// m_axis    out        value[VALUE_BITS-1:0], status  value_valid, more_pending,      list_done
//                      [1:0], zero fill to bytes      rejected
//
// One input transaction is taken every cycle while the queue has room, and the parser
// handles one item per cycle unless the output stalls; results leave via the output register.
// Reset is synchronous and active low; it empties the queue and starts a fresh list.
// A stalled output holds the parser, and the four-entry queue keeps input flowing meanwhile.
// Input ready drops only once the queue is full.

// The block turns a text list such as "3,7-10,-2" into the numbers it names. Characters
// arrive as transactions with action code 0; action 1 closes the list and reports its status,
// and action 2 pulls the next value of a pending range. The front end classifies each
// character (digit, whitespace, comma, sign) and drops action code 3, which has no effect.
// Classified items wait in a short queue. The back end runs the list parser, which keeps the
// accumulated magnitude, the range bounds and the error status, and it owns the output
// register. The digit accumulate is a multiply by ten done as two shifts and an add.
module number_range_list_expander_top #(
    parameter int VALUE_BITS = nrle_pkg::VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // char_code[7:0]
    input  logic [7:0] i_s_axis_tdata,
    // action[1:0]
    input  logic [1:0] i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // value[VALUE_BITS-1:0], status[1:0], then zero fill up to whole bytes
    output logic [((VALUE_BITS + 2 + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // value_valid, more_pending, rejected
    output logic [2:0] o_m_axis_tuser,
    // list_done
    output logic o_m_axis_tlast
);
    import nrle_pkg::*;

    localparam int OUT_W = ((VALUE_BITS + 2 + 7) / 8) * 8;

    logic                  w_q_ready;
    logic                  w_push;
    t_item                 w_front_item;
    logic                  w_q_valid;
    logic                  w_pop;
    t_item                 w_q_item;
    logic [VALUE_BITS-1:0] w_value;
    t_flags                w_flags;

    nrle_front u_front (
        .i_valid       (i_s_axis_tvalid),
        .i_action      (i_s_axis_tuser),
        .i_char        (i_s_axis_tdata),
        .i_queue_ready (w_q_ready),
        .o_ready       (o_s_axis_tready),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    nrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    nrle_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_value     (w_value),
        .o_flags     (w_flags)
    );

    // Pack the result: the value in the low bits, the status above it.
    assign o_m_axis_tdata = OUT_W'({w_flags.status, w_value});
    assign o_m_axis_tuser = {w_flags.rejected, w_flags.more_pending, w_flags.value_valid};
    assign o_m_axis_tlast = w_flags.list_done;

endmodule

[design/nrle_front.sv]
module nrle_front (
    input  logic          i_valid,
    input  logic [1:0]    i_action,
    input  logic [7:0]    i_char,
    input  logic          i_queue_ready,
    output logic          o_ready,
    output logic          o_push,
    output nrle_pkg::t_item o_item
);
    import nrle_pkg::*;

    logic w_known;

    // Action code 3 has no effect, so it is accepted and dropped here.
    assign w_known = (i_action == ACT_CHAR) || (i_action == ACT_END) ||
                     (i_action == ACT_PULL);

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready && w_known;

    always_comb begin
        o_item.kind     = t_action'(i_action);
        o_item.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_item.is_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
        o_item.is_comma = (i_char == CH_COMMA);
        o_item.is_minus = (i_char == CH_MINUS);
        o_item.is_plus  = (i_char == CH_PLUS);
        o_item.digit    = i_char[3:0];
    end

endmodule

[design/nrle_queue.sv]
`include "number_range_list_expander_top_macros.svh"

module nrle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nrle_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output nrle_pkg::t_item o_item
);
    import nrle_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `NRLE_ASSERT(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

[design/nrle_back.sv]
`include "number_range_list_expander_top_macros.svh"

module nrle_back #(
    parameter int VALUE_BITS = nrle_pkg::VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  nrle_pkg::t_item        i_item,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_BITS-1:0]  o_value,
    output nrle_pkg::t_flags       o_flags
);
    import nrle_pkg::*;

    localparam int N = VALUE_BITS;

    // Parser state.
    t_phase        r_phase,  n_phase;
    logic          r_neg,    n_neg;
    logic [N:0]    r_mag,    n_mag;
    logic [N-1:0]  r_start,  n_start;
    logic [N-1:0]  r_next,   n_next;
    logic [N-1:0]  r_last,   n_last;
    logic          r_active, n_active;
    logic          r_end,    n_end;
    t_status       r_err,    n_err;

    // Output register.
    logic          r_out_valid;
    logic [N-1:0]  r_out_value;
    t_flags        r_out_flags;

    logic          w_pop;
    logic          w_ok;
    logic [N+3:0]  w_prod;
    logic [N+3:0]  w_limit;
    logic          w_ovf;
    logic [N-1:0]  w_num;
    logic          w_desc;
    logic          w_arm;
    logic          w_end_holds;
    logic          w_close;
    logic          w_clear;
    logic          w_fire;
    logic [N-1:0]  w_val;
    t_flags        w_flags;

    assign w_pop = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop = w_pop;
    assign w_ok  = (r_err == ST_OK);

    // Accumulate one digit: mag * 10 + d, and check against the signed limit.
    assign w_prod  = ({3'b000, r_mag} << 3) + ({3'b000, r_mag} << 1) +
                     (N + 4)'(i_item.digit);
    assign w_limit = {4'b0000, r_neg, {(N - 1){!r_neg}}};
    assign w_ovf   = (w_prod > w_limit);

    assign w_num  = r_neg ? ({N{1'b0}} - r_mag[N-1:0]) : r_mag[N-1:0];
    assign w_desc = ($signed(w_num) < $signed(r_start));
    assign w_arm  = ($signed(r_start) < $signed(w_num));

    // An end item that arms a range leaves the list open until the last pull.
    assign w_end_holds = w_ok && (r_phase == PH_DIG2) && !w_desc && w_arm;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_pop) begin
            case (i_item.kind)
                ACT_PULL: begin
                    if (r_active && ((r_next + 1'b1) == r_last) && r_end) begin
                        n_phase = PH_NUM1;
                    end
                end
                ACT_END: begin
                    if (!r_active && !w_end_holds) begin
                        n_phase = PH_NUM1;
                    end
                end
                ACT_CHAR: begin
                    if (!r_active && w_ok) begin
                        case (r_phase)
                            PH_NUM1, PH_NUM2: begin
                                if (i_item.is_plus || i_item.is_minus) begin
                                    n_phase = (r_phase == PH_NUM1) ? PH_SIGN1 : PH_SIGN2;
                                end else if (i_item.is_digit) begin
                                    n_phase = (r_phase == PH_NUM1) ? PH_DIG1 : PH_DIG2;
                                end
                            end
                            PH_SIGN1: begin
                                if (i_item.is_digit) begin
                                    n_phase = PH_DIG1;
                                end
                            end
                            PH_SIGN2: begin
                                if (i_item.is_digit) begin
                                    n_phase = PH_DIG2;
                                end
                            end
                            PH_DIG1, PH_AFTER1: begin
                                if (i_item.is_digit && (r_phase == PH_DIG1)) begin
                                    n_phase = PH_DIG1;
                                end else if (i_item.is_comma) begin
                                    n_phase = PH_NUM1;
                                end else if (i_item.is_minus) begin
                                    n_phase = PH_NUM2;
                                end else if (i_item.is_space) begin
                                    n_phase = PH_AFTER1;
                                end
                            end
                            PH_DIG2: begin
                                if (!i_item.is_digit && !w_desc) begin
                                    if (i_item.is_space) begin
                                        n_phase = PH_AFTER2;
                                    end else if (i_item.is_comma) begin
                                        n_phase = PH_NUM1;
                                    end
                                end
                            end
                            PH_AFTER2: begin
                                if (i_item.is_comma) begin
                                    n_phase = PH_NUM1;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Datapath updates and the result of the current item.
    always_comb begin
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_start  = r_start;
        n_next   = r_next;
        n_last   = r_last;
        n_active = r_active;
        n_end    = r_end;
        n_err    = r_err;
        w_close  = 1'b0;
        w_clear  = 1'b0;
        w_val    = '0;
        w_flags  = '0;
        if (w_pop) begin
            case (i_item.kind)
                ACT_PULL: begin
                    if (r_active) begin
                        n_next = r_next + 1'b1;
                        w_val  = n_next;
                        w_flags.value_valid = 1'b1;
                        if (n_next == r_last) begin
                            n_active = 1'b0;
                            if (r_end) begin
                                w_flags.list_done = 1'b1;
                                w_flags.status    = r_err;
                                w_clear           = 1'b1;
                            end
                        end
                    end
                end
                ACT_CHAR: begin
                    if (r_active) begin
                        w_flags.rejected = 1'b1;
                    end else if (w_ok) begin
                        case (r_phase)
                            PH_NUM1, PH_NUM2: begin
                                n_neg = 1'b0;
                                n_mag = '0;
                                if (i_item.is_plus || i_item.is_minus) begin
                                    n_neg = i_item.is_minus;
                                end else if (i_item.is_digit) begin
                                    n_mag = (N + 1)'(i_item.digit);
                                end else if (!i_item.is_space) begin
                                    n_err = ST_SYNTAX;
                                end
                            end
                            PH_SIGN1, PH_SIGN2: begin
                                if (!i_item.is_digit) begin
                                    n_err = ST_SYNTAX;
                                end else if (w_ovf) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    n_mag = w_prod[N:0];
                                end
                            end
                            PH_DIG1: begin
                                if (i_item.is_digit) begin
                                    if (w_ovf) begin
                                        n_err = ST_OVERFLOW;
                                    end else begin
                                        n_mag = w_prod[N:0];
                                    end
                                end else begin
                                    w_val   = w_num;
                                    n_start = w_num;
                                    w_flags.value_valid = 1'b1;
                                    if (!(i_item.is_space || i_item.is_comma ||
                                          i_item.is_minus)) begin
                                        n_err = ST_SYNTAX;
                                    end
                                end
                            end
                            PH_AFTER1: begin
                                if (!(i_item.is_space || i_item.is_comma ||
                                      i_item.is_minus)) begin
                                    n_err = ST_SYNTAX;
                                end
                            end
                            PH_DIG2: begin
                                if (i_item.is_digit) begin
                                    if (w_ovf) begin
                                        n_err = ST_OVERFLOW;
                                    end else begin
                                        n_mag = w_prod[N:0];
                                    end
                                end else if (w_desc) begin
                                    n_err = ST_DESCEND;
                                end else begin
                                    n_last   = w_num;
                                    n_next   = r_start;
                                    n_active = w_arm;
                                    if (!(i_item.is_space || i_item.is_comma)) begin
                                        n_err = ST_SYNTAX;
                                    end
                                end
                            end
                            PH_AFTER2: begin
                                if (!(i_item.is_space || i_item.is_comma)) begin
                                    n_err = ST_SYNTAX;
                                end
                            end
                            default: begin
                                n_err = r_err;
                            end
                        endcase
                    end
                end
                ACT_END: begin
                    if (r_active) begin
                        w_flags.rejected = 1'b1;
                    end else begin
                        w_close = 1'b1;
                        if (w_ok) begin
                            case (r_phase)
                                PH_DIG1: begin
                                    w_val = w_num;
                                    w_flags.value_valid = 1'b1;
                                end
                                PH_AFTER1, PH_AFTER2: begin
                                    w_close = 1'b1;
                                end
                                PH_DIG2: begin
                                    if (w_desc) begin
                                        n_err = ST_DESCEND;
                                    end else begin
                                        n_last   = w_num;
                                        n_next   = r_start;
                                        n_active = w_arm;
                                        if (w_arm) begin
                                            n_end   = 1'b1;
                                            w_close = 1'b0;
                                        end
                                    end
                                end
                                default: begin
                                    n_err = ST_SYNTAX;
                                end
                            endcase
                        end
                        if (w_close) begin
                            w_flags.list_done = 1'b1;
                            w_flags.status    = n_err;
                            w_clear           = 1'b1;
                        end
                    end
                end
                default: begin
                    n_err = r_err;
                end
            endcase
            if (w_clear) begin
                n_neg    = 1'b0;
                n_mag    = '0;
                n_start  = '0;
                n_next   = '0;
                n_last   = '0;
                n_active = 1'b0;
                n_end    = 1'b0;
                n_err    = ST_OK;
            end
        end
        w_flags.more_pending = n_active;
    end

    assign w_fire = w_flags.value_valid || w_flags.list_done || w_flags.rejected ||
                    w_flags.more_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_NUM1;
            r_neg    <= 1'b0;
            r_mag    <= '0;
            r_start  <= '0;
            r_next   <= '0;
            r_last   <= '0;
            r_active <= 1'b0;
            r_end    <= 1'b0;
            r_err    <= ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_mag    <= n_mag;
            r_start  <= n_start;
            r_next   <= n_next;
            r_last   <= n_last;
            r_active <= n_active;
            r_end    <= n_end;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= w_fire;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_value <= w_val;
            r_out_flags <= w_flags;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_flags     = r_out_flags;

    `NRLE_ASSERT_IMPLY(a_end_needs_range, r_end, r_active, "end seen without armed range")
    `NRLE_ASSERT_IMPLY(a_range_phase, r_active,
        (r_phase == PH_DIG2) || (r_phase == PH_AFTER2) || (r_phase == PH_NUM1),
        "range armed in an unexpected phase")
    `NRLE_ASSERT_IMPLY(a_done_no_more, r_out_valid && r_out_flags.list_done,
        !r_out_flags.more_pending, "list closed while range values remain")
    `NRLE_ASSERT_IMPLY(a_reject_alone, r_out_valid && r_out_flags.rejected,
        !r_out_flags.value_valid && !r_out_flags.list_done,
        "rejected transaction carries a value or a close")

endmodule
